// ===== design/gsc_pkg.sv =====
// Shared types and constants of the glyph slot cache.
`timescale 1ns / 1ps

package gsc_pkg;

   localparam int CODE_W    = 21;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 8;
   localparam int CELL_W    = 11;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;

   localparam int DEF_SLOT_COUNT   = 256;
   localparam int DEF_GRID_COLUMNS = 16;
   localparam int DEF_STAMP_BITS   = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_CELL_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_HEIGHT = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_HIT     = 2'd0,
      STATUS_INSTALL = 2'd1,
      STATUS_SKIP    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic hit;
      logic victim_valid;
   } sel_flags_type;

endpackage

// ===== design/gsc_req_if.sv =====
// Request channel of the glyph slot cache.
`timescale 1ns / 1ps

interface gsc_req_if import gsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] char_code;
   logic              glyph_loadable;

   modport source (output valid, output char_code, output glyph_loadable, input ready);
   modport sink   (input valid, input char_code, input glyph_loadable, output ready);
endinterface

// ===== design/gsc_rsp_if.sv =====
// Response channel of the glyph slot cache.
`timescale 1ns / 1ps

interface gsc_rsp_if import gsc_pkg::*; ();
   logic              valid;
   logic              ready;
   status_type        status;
   logic [SLOT_W-1:0] slot_index;
   logic [CELL_W-1:0] cell_x;
   logic [CELL_W-1:0] cell_y;
   logic              evicted_valid;
   logic [CODE_W-1:0] evicted_code;

   modport source (output valid, output status, output slot_index, output cell_x,
                   output cell_y, output evicted_valid, output evicted_code, input ready);
   modport sink   (input valid, input status, input slot_index, input cell_x,
                   input cell_y, input evicted_valid, input evicted_code, output ready);
endinterface

// ===== design/glyph_slot_cache_lru_unit.sv =====
// Top level of the glyph slot cache with least-recently-used replacement.
//
// A request on req_ch carries a code point and a loadable flag. The unit looks
// the code up over all SLOT_COUNT slots and answers on rsp_ch with one response:
// hit, miss and installed (the oldest slot by wrapping stamp age is replaced),
// or miss and not loadable. The response gives the slot, its atlas cell
// offsets and the code that was evicted.
// Slot state sits in one synchronous memory that is swept once per request,
// one entry per cycle; that sweep sets the rate. After the sweep a drain state
// and an update state follow, and the response is loaded into its register;
// a new request is taken only in the idle state, after that update.
// After reset the unit clears the slot memory in one pass over all SLOT_COUNT slots,
// with req_ch.ready low; csr writes are taken at any time and set the cell
// width and height less one. The response is held in an output register: a stalled
// receiver does not block acceptance of the next request, which is then swept
// and waits to write back until the held response is taken.
`timescale 1ns / 1ps

module glyph_slot_cache_lru_unit import gsc_pkg::*; #(
   parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
   parameter int GRID_COLUMNS = DEF_GRID_COLUMNS,
   parameter int STAMP_BITS   = DEF_STAMP_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   gsc_req_if.sink              req_ch,
   gsc_rsp_if.source            rsp_ch,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data
);

   localparam int IDX_W   = $clog2(SLOT_COUNT);
   localparam int COL_W   = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
   localparam int ENTRY_W = 1 + CODE_W + STAMP_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_COLUMNS - 1);

   state_type state_ff, state_in;

   logic [ENTRY_W-1:0] mem [SLOT_COUNT];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [IDX_W-1:0]      row_ff, row_in;
   logic                  cmp_vld_ff;
   logic [IDX_W-1:0]      cmp_idx_ff;
   logic [COL_W-1:0]      cmp_col_ff;
   logic [IDX_W-1:0]      cmp_row_ff;
   logic [STAMP_BITS-1:0] use_cnt_ff, use_cnt_in;
   logic [CODE_W-1:0]     code_ff;
   logic                  loadable_ff;
   logic [CFG_W-1:0]      cell_w_ff;
   logic [CFG_W-1:0]      cell_h_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [CELL_W-1:0]     rsp_x_ff;
   logic [CELL_W-1:0]     rsp_y_ff;
   logic                  rsp_ev_valid_ff;
   logic [CODE_W-1:0]     rsp_ev_code_ff;

   logic                  req_fire;
   logic                  addr_last;
   logic                  out_free;
   logic                  issue;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [ENTRY_W-1:0]    mem_wdata;
   logic                  load_rsp;
   logic                  count_adv;

   sel_flags_type         sel_flags;
   logic [CODE_W-1:0]     victim_code;
   logic [IDX_W-1:0]      slot_idx;
   logic [COL_W-1:0]      slot_col;
   logic [IDX_W-1:0]      slot_row;
   logic [COL_W+CFG_W:0]  prod_x;
   logic [IDX_W+CFG_W:0]  prod_y;

   gsc_lru_select #(
      .SLOT_COUNT   (SLOT_COUNT),
      .GRID_COLUMNS (GRID_COLUMNS),
      .STAMP_BITS   (STAMP_BITS)
   ) u_select (
      .clock       (clock),
      .reset       (reset),
      .cmp_valid   (cmp_vld_ff),
      .cmp_idx     (cmp_idx_ff),
      .cmp_col     (cmp_col_ff),
      .cmp_row     (cmp_row_ff),
      .ent_valid   (rd_data_ff[ENTRY_W-1]),
      .ent_code    (rd_data_ff[ENTRY_W-2 -: CODE_W]),
      .ent_stamp   (rd_data_ff[STAMP_BITS-1:0]),
      .req_code    (code_ff),
      .use_count   (use_cnt_ff),
      .sel_flags   (sel_flags),
      .victim_code (victim_code),
      .slot_idx    (slot_idx),
      .slot_col    (slot_col),
      .slot_row    (slot_row)
   );

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign addr_last = (addr_ff == LAST_IDX);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (addr_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_fire) state_in = ST_SCAN;
         ST_SCAN:   if (addr_last) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_UPDATE;
         ST_UPDATE: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      issue        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = slot_idx;
      mem_wdata    = {1'b1, code_ff, use_cnt_ff};
      load_rsp     = 1'b0;
      count_adv    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff;
            mem_wdata = '0;
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         ST_SCAN: begin
            issue = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_UPDATE: begin
            load_rsp  = out_free;
            count_adv = out_free && (sel_flags.hit || loadable_ff);
            mem_we    = count_adv;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      addr_in    = addr_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      use_cnt_in = count_adv ? use_cnt_ff + 1'b1 : use_cnt_ff;
      if (state_ff == ST_IDLE) begin
         addr_in = '0;
         col_in  = '0;
         row_in  = '0;
      end else if (state_ff == ST_CLEAR || issue) begin
         addr_in = addr_ff + 1'b1;
         if (col_ff == LAST_COL) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         use_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         cell_w_ff    <= CFG_W'(1);
         cell_h_ff    <= CFG_W'(1);
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cmp_vld_ff   <= issue;
         use_cnt_ff   <= use_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_CELL_WIDTH:  cell_w_ff <= csr_write_data;
               CSR_CELL_HEIGHT: cell_h_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= addr_ff;
      cmp_col_ff <= col_ff;
      cmp_row_ff <= row_ff;
      if (req_fire) begin
         code_ff     <= req_ch.char_code;
         loadable_ff <= req_ch.glyph_loadable;
      end
   end

   assign prod_x = slot_col * ({1'b0, cell_w_ff} + 1'b1);
   assign prod_y = slot_row * ({1'b0, cell_h_ff} + 1'b1);

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         if (sel_flags.hit || loadable_ff) begin
            if (sel_flags.hit) begin
               rsp_status_ff <= STATUS_HIT;
            end else begin
               rsp_status_ff <= STATUS_INSTALL;
            end
            rsp_slot_ff     <= SLOT_W'(slot_idx);
            rsp_x_ff        <= CELL_W'(prod_x);
            rsp_y_ff        <= CELL_W'(prod_y);
            rsp_ev_valid_ff <= !sel_flags.hit && sel_flags.victim_valid;
            rsp_ev_code_ff  <= sel_flags.hit ? '0 : victim_code;
         end else begin
            rsp_status_ff   <= STATUS_SKIP;
            rsp_slot_ff     <= '0;
            rsp_x_ff        <= '0;
            rsp_y_ff        <= '0;
            rsp_ev_valid_ff <= 1'b0;
            rsp_ev_code_ff  <= '0;
         end
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.slot_index    = rsp_slot_ff;
   assign rsp_ch.cell_x        = rsp_x_ff;
   assign rsp_ch.cell_y        = rsp_y_ff;
   assign rsp_ch.evicted_valid = rsp_ev_valid_ff;
   assign rsp_ch.evicted_code  = rsp_ev_code_ff;

   a_update_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && out_free) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("update did not deliver a response");

   a_counter_moves_on_write: assert property (@(posedge clock) disable iff (reset)
      (use_cnt_ff != $past(use_cnt_ff)) |-> ($past(mem_we) && $past(state_ff == ST_UPDATE)))
      else $error("stamp counter advanced without a slot write");

   a_skip_is_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_SKIP) |->
      (rsp_slot_ff == '0 && !rsp_ev_valid_ff && rsp_ev_code_ff == '0))
      else $error("not-loadable response carries slot data");

   a_hit_no_eviction: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_HIT) |-> !rsp_ev_valid_ff)
      else $error("hit response reports an eviction");

   a_scan_idle_ready: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("compare stage active outside a sweep");

endmodule

// ===== design/gsc_lru_select.sv =====
// Hit match and oldest-slot tracking over the streamed slot entries.
`timescale 1ns / 1ps

module gsc_lru_select import gsc_pkg::*; #(
   parameter int SLOT_COUNT   = DEF_SLOT_COUNT,
   parameter int GRID_COLUMNS = DEF_GRID_COLUMNS,
   parameter int STAMP_BITS   = DEF_STAMP_BITS,
   localparam int IDX_W = $clog2(SLOT_COUNT),
   localparam int COL_W = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmp_valid,
   input  logic [IDX_W-1:0]      cmp_idx,
   input  logic [COL_W-1:0]      cmp_col,
   input  logic [IDX_W-1:0]      cmp_row,
   input  logic                  ent_valid,
   input  logic [CODE_W-1:0]     ent_code,
   input  logic [STAMP_BITS-1:0] ent_stamp,
   input  logic [CODE_W-1:0]     req_code,
   input  logic [STAMP_BITS-1:0] use_count,
   output sel_flags_type         sel_flags,
   output logic [CODE_W-1:0]     victim_code,
   output logic [IDX_W-1:0]      slot_idx,
   output logic [COL_W-1:0]      slot_col,
   output logic [IDX_W-1:0]      slot_row
);

   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      hit_idx_ff;
   logic [COL_W-1:0]      hit_col_ff;
   logic [IDX_W-1:0]      hit_row_ff;
   logic [STAMP_BITS-1:0] best_age_ff;
   logic [IDX_W-1:0]      vic_idx_ff;
   logic [COL_W-1:0]      vic_col_ff;
   logic [IDX_W-1:0]      vic_row_ff;
   logic                  vic_valid_ff;
   logic [CODE_W-1:0]     vic_code_ff;

   logic                  first;
   logic                  match;
   logic                  take_hit;
   logic                  take_vic;
   logic [STAMP_BITS-1:0] age;

   always_comb begin
      first    = (cmp_idx == '0);
      match    = ent_valid && (ent_code == req_code);
      take_hit = cmp_valid && match && (first || !hit_ff);
      age      = use_count - ent_stamp;
      take_vic = cmp_valid && (first || (age > best_age_ff));
      hit_in   = hit_ff;
      if (cmp_valid) begin
         hit_in = first ? match : (hit_ff || match);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_hit) begin
         hit_idx_ff <= cmp_idx;
         hit_col_ff <= cmp_col;
         hit_row_ff <= cmp_row;
      end
      if (take_vic) begin
         best_age_ff  <= age;
         vic_idx_ff   <= cmp_idx;
         vic_col_ff   <= cmp_col;
         vic_row_ff   <= cmp_row;
         vic_valid_ff <= ent_valid;
         vic_code_ff  <= ent_code;
      end
   end

   always_comb begin
      sel_flags.hit          = hit_ff;
      sel_flags.victim_valid = vic_valid_ff;
      victim_code            = vic_valid_ff ? vic_code_ff : '0;
      slot_idx               = hit_ff ? hit_idx_ff : vic_idx_ff;
      slot_col               = hit_ff ? hit_col_ff : vic_col_ff;
      slot_row               = hit_ff ? hit_row_ff : vic_row_ff;
   end

endmodule
